// ----- design/hhhm_pkg.sv -----
`timescale 1ns / 1ps
// shared types, constants and the header key table for the host header matcher
// no dependencies

package hhhm_pkg;

    localparam int DATA_W     = 8;
    localparam int CNT_W      = 8;
    localparam int PLEN_W     = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;
    localparam int M_TDATA_W  = 16;
    localparam int MAX_PAT    = 16;
    localparam int PIDX_W     = 4;
    localparam int KPOS_W     = 3;

    localparam logic [DATA_W-1:0] CH_CR = 8'h0D;
    localparam logic [DATA_W-1:0] CH_LF = 8'h0A;
    localparam logic [KPOS_W-1:0] KEY_LAST_POS = 3'd7;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PAT_LO  = 2'd0,
        CFG_PAT_HI  = 2'd1,
        CFG_PAT_LEN = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        PH_SEARCH = 3'b001,
        PH_VALUE  = 3'b010,
        PH_DONE   = 3'b100
    } t_phase;

    // value bytes taken by one beat: a held-back cr, then the beat's own byte
    typedef struct packed {
        logic              step;
        logic              last;
        logic              take0;
        logic              take1;
        logic [CNT_W-1:0]  idx0;
        logic [CNT_W-1:0]  idx1;
        logic [DATA_W-1:0] byte1;
        logic              found;
        logic [CNT_W-1:0]  count;
    } t_scan_ev;

    typedef struct packed {
        logic             match;
        logic             found;
        logic [CNT_W-1:0] length;
    } t_result;

    // cr lf "Host: "
    function automatic logic [DATA_W-1:0] key_byte(input logic [KPOS_W-1:0] pos);
        logic [DATA_W-1:0] b;
        case (pos)
            3'd0:    b = CH_CR;
            3'd1:    b = CH_LF;
            3'd2:    b = 8'h48;
            3'd3:    b = 8'h6F;
            3'd4:    b = 8'h73;
            3'd5:    b = 8'h74;
            3'd6:    b = 8'h3A;
            3'd7:    b = 8'h20;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ----- design/hhhm_scan.sv -----
`timescale 1ns / 1ps
// header key search and value delimiting: phase, key position, cr hold, value count
// depends on hhhm_pkg

module hhhm_scan #(
    parameter int VALUE_LIMIT = 255
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_step,
    input  logic [hhhm_pkg::DATA_W-1:0] i_byte,
    input  logic                       i_last,
    output hhhm_pkg::t_scan_ev         o_ev
);

    localparam logic [hhhm_pkg::CNT_W-1:0] LIMIT = hhhm_pkg::CNT_W'(VALUE_LIMIT);

    hhhm_pkg::t_phase                  r_phase, n_phase;
    logic [hhhm_pkg::KPOS_W-1:0]       r_kpos, n_kpos;
    logic                              r_cp, n_cp;
    logic [hhhm_pkg::CNT_W-1:0]        r_count, n_count;

    always_comb begin
        logic                       take0;
        logic                       take1;
        logic [hhhm_pkg::CNT_W-1:0] c1;
        n_phase = r_phase;
        n_kpos  = r_kpos;
        n_cp    = r_cp;
        take0   = 1'b0;
        take1   = 1'b0;
        case (r_phase)
            hhhm_pkg::PH_SEARCH: begin
                if (i_byte == hhhm_pkg::key_byte(r_kpos)) begin
                    if (r_kpos == hhhm_pkg::KEY_LAST_POS) begin
                        n_kpos  = '0;
                        n_phase = hhhm_pkg::PH_VALUE;
                    end else begin
                        n_kpos = r_kpos + 1'b1;
                    end
                end else begin
                    // a cr may open the key again
                    n_kpos = (i_byte == hhhm_pkg::CH_CR) ? 3'd1 : 3'd0;
                end
            end
            hhhm_pkg::PH_VALUE: begin
                if (r_cp && i_byte == hhhm_pkg::CH_LF) begin
                    n_cp    = 1'b0;
                    n_phase = hhhm_pkg::PH_DONE;
                end else begin
                    // a held cr without lf becomes a value byte
                    take0 = r_cp;
                    take1 = (i_byte != hhhm_pkg::CH_CR);
                    n_cp  = (i_byte == hhhm_pkg::CH_CR);
                end
            end
            default: begin
            end
        endcase

        c1      = (take0 && r_count < LIMIT) ? r_count + 1'b1 : r_count;
        n_count = (take1 && c1 < LIMIT) ? c1 + 1'b1 : c1;

        o_ev.step  = i_step;
        o_ev.last  = i_last;
        o_ev.take0 = take0;
        o_ev.take1 = take1;
        o_ev.idx0  = r_count;
        o_ev.idx1  = c1;
        o_ev.byte1 = i_byte;
        o_ev.found = (n_phase != hhhm_pkg::PH_SEARCH) && (n_phase != hhhm_pkg::PH_VALUE);
        o_ev.count = n_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= hhhm_pkg::PH_SEARCH;
            r_kpos  <= '0;
            r_cp    <= 1'b0;
            r_count <= '0;
        end else if (i_step) begin
            if (i_last) begin
                r_phase <= hhhm_pkg::PH_SEARCH;
                r_kpos  <= '0;
                r_cp    <= 1'b0;
                r_count <= '0;
            end else begin
                r_phase <= n_phase;
                r_kpos  <= n_kpos;
                r_cp    <= n_cp;
                r_count <= n_count;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && i_last |=> r_phase == hhhm_pkg::PH_SEARCH && r_count == '0 && !r_cp)
        else $error("scan state not cleared after last beat");

    a_cr_only_in_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cp |-> r_phase == hhhm_pkg::PH_VALUE)
        else $error("cr held outside value phase");
`endif

endmodule

// ----- design/hhhm_prefix.sv -----
`timescale 1ns / 1ps
// pattern registers, running prefix compare and end-of-payload verdict
// depends on hhhm_pkg

module hhhm_prefix #(
    parameter int PATTERN_BYTES = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wen,
    input  logic [hhhm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [hhhm_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  hhhm_pkg::t_scan_ev             i_ev,
    output hhhm_pkg::t_result              o_result
);

    localparam logic [hhhm_pkg::PLEN_W-1:0] PB = hhhm_pkg::PLEN_W'(PATTERN_BYTES);

    logic [hhhm_pkg::DATA_W-1:0] w_pat [hhhm_pkg::MAX_PAT];
    logic [hhhm_pkg::PLEN_W-1:0] r_plen;
    logic [hhhm_pkg::PLEN_W-1:0] w_plen;
    logic                        r_mm, n_mm;

    for (genvar gi = 0; gi < hhhm_pkg::MAX_PAT; gi++) begin : g_pat
        if (gi < PATTERN_BYTES) begin : g_used
            localparam int LANE = gi % 8;
            localparam hhhm_pkg::t_cfg_idx WORD =
                (gi < 8) ? hhhm_pkg::CFG_PAT_LO : hhhm_pkg::CFG_PAT_HI;
            logic [hhhm_pkg::DATA_W-1:0] r_byte;
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_byte <= '0;
                end else if (i_cfg_wen && i_cfg_index == WORD) begin
                    r_byte <= i_cfg_wdata[LANE*8 +: 8];
                end
            end
            assign w_pat[gi] = r_byte;
        end else begin : g_none
            assign w_pat[gi] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plen <= '0;
        end else if (i_cfg_wen && i_cfg_index == hhhm_pkg::CFG_PAT_LEN) begin
            r_plen <= i_cfg_wdata[hhhm_pkg::PLEN_W-1:0];
        end
    end

    assign w_plen = (r_plen > PB) ? PB : r_plen;

    always_comb begin
        logic                       m0;
        logic                       m1;
        logic                       tail_bad;
        logic [hhhm_pkg::CNT_W-1:0] start;
        m0 = i_ev.take0 && (i_ev.idx0 < {3'b000, w_plen})
             && (w_pat[i_ev.idx0[hhhm_pkg::PIDX_W-1:0]] != hhhm_pkg::CH_CR);
        m1 = i_ev.take1 && (i_ev.idx1 < {3'b000, w_plen})
             && (w_pat[i_ev.idx1[hhhm_pkg::PIDX_W-1:0]] != i_ev.byte1);
        n_mm = r_mm | m0 | m1;

        // pattern bytes past the value's end must be zero
        start    = i_ev.found ? i_ev.count : '0;
        tail_bad = 1'b0;
        for (int i = 0; i < hhhm_pkg::MAX_PAT; i++) begin
            if (hhhm_pkg::CNT_W'(i) >= start && hhhm_pkg::PLEN_W'(i) < w_plen
                && w_pat[i] != '0) begin
                tail_bad = 1'b1;
            end
        end

        o_result.found  = i_ev.found;
        o_result.length = i_ev.found ? i_ev.count : '0;
        o_result.match  = (i_ev.found ? !n_mm : 1'b1) && !tail_bad;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mm <= 1'b0;
        end else if (i_ev.step) begin
            r_mm <= i_ev.last ? 1'b0 : n_mm;
        end
    end

endmodule

// ----- design/http_host_header_matcher_unit.sv -----
`timescale 1ns / 1ps
// a result is registered in the output stage when its last payload beat leaves the input register
// throughput: one payload beat per cycle while no result is held on the output, set by the scan state update
// the input register stalls only while a result waits on the output
// reset (synchronous, active low) clears scan state, pattern registers and both stages
// depends on hhhm_pkg, hhhm_scan, hhhm_prefix

module http_host_header_matcher_unit #(
    parameter int PATTERN_BYTES = 16,
    parameter int VALUE_LIMIT   = 255
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wen,
    input  logic [hhhm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [hhhm_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [hhhm_pkg::DATA_W-1:0]      i_s_tdata,   // [7:0] data_byte
    input  logic                            i_s_tlast,   // last_in_payload
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [hhhm_pkg::M_TDATA_W-1:0]   o_m_tdata    // [0] host_match, [1] host_found,
                                                         // [9:2] value_length, [15:10] zero
);

    logic                        r_in_valid;
    logic [hhhm_pkg::DATA_W-1:0] r_in_byte;
    logic                        r_in_last;
    logic                        r_out_valid;
    hhhm_pkg::t_result           r_out;
    logic                        w_adv;
    logic                        w_step;
    hhhm_pkg::t_scan_ev          w_ev;
    hhhm_pkg::t_result           w_result;

    assign w_adv      = !r_out_valid || i_m_tready;
    assign w_step     = w_adv && r_in_valid;
    assign o_s_tready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in_byte <= i_s_tdata;
            r_in_last <= i_s_tlast;
        end
    end

    hhhm_scan #(
        .VALUE_LIMIT(VALUE_LIMIT)
    ) u_scan (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_step (w_step),
        .i_byte (r_in_byte),
        .i_last (r_in_last),
        .o_ev   (w_ev)
    );

    hhhm_prefix #(
        .PATTERN_BYTES(PATTERN_BYTES)
    ) u_prefix (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_wen  (i_cfg_wen),
        .i_cfg_index(i_cfg_index),
        .i_cfg_wdata(i_cfg_wdata),
        .i_ev       (w_ev),
        .o_result   (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_step && r_in_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step && r_in_last) begin
            r_out <= w_result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {6'b000000, r_out.length, r_out.found, r_out.match};

`ifndef NO_ASSERTIONS
    a_result_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(r_in_valid && r_in_last))
        else $error("result raised without a last beat");

    a_missing_len_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tdata[1] |-> o_m_tdata[9:2] == '0)
        else $error("length reported without host value");

    a_len_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[9:2] <= hhhm_pkg::CNT_W'(VALUE_LIMIT))
        else $error("value length above limit");
`endif

endmodule

// ----- verif/http_host_header_matcher_checker.sv -----
`timescale 1ns / 1ps
// scoreboard for the host header matcher: tracks the config port, predicts one
// result per finished payload and compares it with the result stream
// depends on hhhm_pkg

module http_host_header_matcher_checker
    import hhhm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wen,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_s_tvalid,
    input  logic                  i_s_tready,
    input  logic [DATA_W-1:0]     i_s_tdata,
    input  logic                  i_s_tlast,
    input  logic                  i_m_tvalid,
    input  logic                  i_m_tready,
    input  logic [M_TDATA_W-1:0]  i_m_tdata,
    output int                    o_fail_count,
    output int                    o_pending
);

    localparam int VALUE_CAP = 255;
    localparam int SHOW_LIMIT = 10;
    // cr lf "Host: ", first key byte in the lowest bits
    localparam logic [63:0] HOST_KEY =
        {8'h20, 8'h3A, 8'h74, 8'h73, 8'h6F, 8'h48, 8'h0A, 8'h0D};

    logic [63:0]       pat_lo = '0;
    logic [63:0]       pat_hi = '0;
    logic [PLEN_W-1:0] pat_len = '0;

    t_phase            scan_ph = PH_SEARCH;
    logic [KPOS_W-1:0] key_pos = '0;
    logic [CNT_W-1:0]  val_cnt = '0;
    logic              cr_held = 1'b0;
    logic              prefix_bad = 1'b0;

    t_result           host_results_q[$];

    function automatic logic [7:0] pattern_byte(input logic [3:0] idx);
        logic [63:0] word;
        word = idx[3] ? pat_hi : pat_lo;
        return word[idx[2:0]*8 +: 8];
    endfunction

    function automatic int compare_span();
        return (int'(pat_len) > MAX_PAT) ? MAX_PAT : int'(pat_len);
    endfunction

    task automatic clear_scan();
        scan_ph = PH_SEARCH;
        key_pos = '0;
        val_cnt = '0;
        cr_held = 1'b0;
        prefix_bad = 1'b0;
    endtask

    task automatic take_value(input logic [7:0] b);
        if (int'(val_cnt) < compare_span() && b != pattern_byte(val_cnt[3:0]))
            prefix_bad = 1'b1;
        if (int'(val_cnt) < VALUE_CAP)
            val_cnt = val_cnt + 1'b1;
    endtask

    task automatic scan_byte(input logic [7:0] b);
        case (scan_ph)
            PH_SEARCH: begin
                if (b == HOST_KEY[key_pos*8 +: 8]) begin
                    if (key_pos == KEY_LAST_POS) begin
                        key_pos = '0;
                        scan_ph = PH_VALUE;
                    end else begin
                        key_pos = key_pos + 1'b1;
                    end
                end else begin
                    // a cr may open a fresh key
                    key_pos = (b == CH_CR) ? 3'd1 : 3'd0;
                end
            end
            PH_VALUE: begin
                if (cr_held && b == CH_LF) begin
                    cr_held = 1'b0;
                    scan_ph = PH_DONE;
                end else begin
                    // a held cr without lf belongs to the value
                    if (cr_held)
                        take_value(CH_CR);
                    if (b == CH_CR) begin
                        cr_held = 1'b1;
                    end else begin
                        cr_held = 1'b0;
                        take_value(b);
                    end
                end
            end
            default: ;
        endcase
    endtask

    function automatic t_result payload_result();
        t_result r;
        int      i;
        int      span;
        r.found = (scan_ph == PH_DONE);
        r.length = r.found ? val_cnt : '0;
        r.match = r.found ? !prefix_bad : 1'b1;
        span = compare_span();
        // the value is padded with zero bytes up to the pattern length
        for (i = r.found ? int'(val_cnt) : 0; i < span; i++) begin
            if (pattern_byte(i[3:0]) != 8'h00)
                r.match = 1'b0;
        end
        return r;
    endfunction

    task automatic note_failure(input string msg);
        o_fail_count++;
        if (o_fail_count <= SHOW_LIMIT)
            $display("[%0t] %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want)
            note_failure($sformatf("%s mismatch: expected %0d, got %0d", name, want, got));
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            pat_lo = '0;
            pat_hi = '0;
            pat_len = '0;
            clear_scan();
            host_results_q.delete();
            o_fail_count = 0;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (host_results_q.size() == 0) begin
                    note_failure($sformatf("unexpected result beat: tdata %h", i_m_tdata));
                end else begin
                    want = host_results_q.pop_front();
                    check_field("host_match", 8'(want.match), 8'(i_m_tdata[0]));
                    check_field("host_found", 8'(want.found), 8'(i_m_tdata[1]));
                    check_field("value_length", want.length, i_m_tdata[9:2]);
                    check_field("pad bits", 8'h00, 8'(i_m_tdata[15:10]));
                end
            end
            if (i_cfg_wen) begin
                case (i_cfg_index)
                    CFG_PAT_LO:  pat_lo = i_cfg_wdata;
                    CFG_PAT_HI:  pat_hi = i_cfg_wdata;
                    CFG_PAT_LEN: pat_len = i_cfg_wdata[PLEN_W-1:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) begin
                scan_byte(i_s_tdata);
                if (i_s_tlast) begin
                    host_results_q.push_back(payload_result());
                    clear_scan();
                end
            end
        end
        o_pending = host_results_q.size();
    end

endmodule

// ----- verif/http_host_header_matcher_unit_tb.sv -----
`timescale 1ns / 1ps
// top of the host header matcher bench: clock, reset, config phases and payload stimulus
// depends on hhhm_pkg, http_host_header_matcher_unit and http_host_header_matcher_checker

module http_host_header_matcher_unit_tb;
    import hhhm_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;
    localparam int PHASE_ITEMS = 210;
    localparam int PHASE_COUNT = 6;
    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_LIMIT = 1000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_wen = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [DATA_W-1:0]     i_s_tdata = '0;    // [7:0] data_byte
    logic                  i_s_tlast = 1'b0;  // last_in_payload
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  o_m_tdata;         // [0] host_match, [1] host_found,
                                              // [9:2] value_length, [15:10] zero

    int          fail_count;
    int          pending;
    int          send_idle = 36;
    int          recv_idle = 65;
    int          sent_items = 0;
    logic [63:0] pat_lo = '0;
    logic [63:0] pat_hi = '0;
    logic [4:0]  pat_len = '0;
    logic [7:0]  payload_q[$];

    http_host_header_matcher_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    http_host_header_matcher_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wen    (i_cfg_wen),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tlast    (i_s_tlast),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(negedge i_clk)
        i_m_tready <= ($urandom_range(99) >= recv_idle);

    function automatic logic [7:0] host_byte();
        return 8'($urandom_range(33, 126));
    endfunction

    function automatic logic [7:0] noise_byte();
        case ($urandom_range(15))
            0, 1:    return CH_CR;
            2:       return CH_LF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [63:0] host_word(input int nbytes);
        logic [63:0] w;
        w = '0;
        for (int i = 0; i < nbytes && i < 8; i++)
            w[i*8 +: 8] = host_byte();
        return w;
    endfunction

    function automatic int pattern_span();
        return (int'(pat_len) > MAX_PAT) ? MAX_PAT : int'(pat_len);
    endfunction

    function automatic logic [7:0] pat_at(input int idx);
        logic [63:0] word;
        word = (idx >= 8) ? pat_hi : pat_lo;
        return word[(idx % 8)*8 +: 8];
    endfunction

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
        @(negedge i_clk);
        i_cfg_wen <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        case (idx)
            CFG_PAT_LO:  pat_lo = data;
            CFG_PAT_HI:  pat_hi = data;
            CFG_PAT_LEN: pat_len = data[4:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_wen <= 1'b0;
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < send_idle) begin
            @(negedge i_clk);
            i_s_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        i_s_tvalid <= 1'b1;
        i_s_tdata <= b;
        i_s_tlast <= last;
        do @(posedge i_clk); while (!o_s_tready);
        sent_items++;
    endtask

    task automatic send_queued();
        foreach (payload_q[i])
            send_byte(payload_q[i], i == payload_q.size() - 1);
    endtask

    // host value bytes with the odd lone cr or arbitrary byte
    task automatic add_value_bytes(input int n);
        repeat (n) begin
            case ($urandom_range(11))
                0: begin
                    payload_q.push_back(CH_CR);
                    payload_q.push_back(host_byte());
                end
                1:       payload_q.push_back(8'($urandom_range(255)));
                default: payload_q.push_back(host_byte());
            endcase
        end
    endtask

    task automatic add_key_bytes(input int n);
        for (int i = 0; i < n; i++)
            payload_q.push_back(key_byte(3'(i)));
    endtask

    task automatic send_payload(input bit long_value);
        int         kind;
        int         span;
        int         k;
        int         pos;
        logic [7:0] b;
        payload_q.delete();
        kind = long_value ? 0 : $urandom_range(99);
        span = pattern_span();
        repeat ($urandom_range(0, 6)) payload_q.push_back(noise_byte());
        if (kind < 80) begin
            if ($urandom_range(4) == 0)
                add_key_bytes($urandom_range(1, 7));
            add_key_bytes(8);
            if (long_value) begin
                add_value_bytes($urandom_range(250, 300));
            end else begin
                case ($urandom_range(3))
                    0: begin
                        for (int i = 0; i < span; i++) payload_q.push_back(pat_at(i));
                        add_value_bytes($urandom_range(0, 6));
                    end
                    1: begin
                        // shorter than the pattern, matches only on zero padding
                        k = (span > 0) ? $urandom_range(0, span - 1) : 0;
                        for (int i = 0; i < k; i++) payload_q.push_back(pat_at(i));
                    end
                    2: begin
                        pos = (span > 0) ? $urandom_range(0, span - 1) : 0;
                        for (int i = 0; i < span; i++) begin
                            b = pat_at(i);
                            if (i == pos)
                                b = b ^ (8'd1 << $urandom_range(7));
                            payload_q.push_back(b);
                        end
                        add_value_bytes($urandom_range(0, 3));
                    end
                    default: add_value_bytes($urandom_range(0, 20));
                endcase
            end
            if (kind < 68) begin
                payload_q.push_back(CH_CR);
                payload_q.push_back(CH_LF);
            end
            repeat ($urandom_range(0, 4)) payload_q.push_back(noise_byte());
        end else if (kind < 90) begin
            // key cut short
            add_key_bytes($urandom_range(1, 7));
            repeat ($urandom_range(0, 5)) payload_q.push_back(noise_byte());
        end else begin
            repeat ($urandom_range(1, 20)) payload_q.push_back(noise_byte());
        end
        if (payload_q.size() == 0)
            payload_q.push_back(noise_byte());
        send_queued();
    endtask

    // every payload ends on a last beat, so after this the block is idle
    task automatic drain();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic configure(input int ph);
        int k;
        case (ph)
            0: begin
                cfg_write(CFG_PAT_LO, host_word(8));
                cfg_write(CFG_PAT_HI, host_word(8));
                cfg_write(CFG_PAT_LEN, 64'd16);
            end
            1: begin
                cfg_write(CFG_PAT_LO, '1);
                cfg_write(CFG_PAT_HI, '1);
                cfg_write(CFG_PAT_LEN, 64'd0);
            end
            2: begin
                cfg_write(CFG_PAT_LO, '0);
                cfg_write(CFG_PAT_HI, '0);
                cfg_write(CFG_PAT_LEN, 64'd31);
            end
            3: begin
                cfg_write(CFG_PAT_LO, host_word(5));
                cfg_write(CFG_PAT_HI, {$urandom, $urandom});
                cfg_write(CFG_PAT_LEN, 64'd5);
            end
            4: begin
                k = $urandom_range(1, 15);
                cfg_write(CFG_PAT_LO, host_word(k));
                cfg_write(CFG_PAT_HI, host_word(k - 8));
                cfg_write(CFG_PAT_LEN, 64'd16);
            end
            default: begin
                cfg_write(CFG_PAT_LO, {$urandom, $urandom});
                cfg_write(CFG_PAT_HI, {$urandom, $urandom});
                cfg_write(CFG_PAT_LEN, 64'($urandom_range(0, 31)));
                cfg_write(CFG_UNUSED_IDX, {$urandom, $urandom});
            end
        endcase
    endtask

    initial begin
        int phase_start;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // pattern "a" cr "b", three bytes
        cfg_write(CFG_PAT_LO, {40'h0, 8'h62, CH_CR, 8'h61});
        cfg_write(CFG_PAT_HI, 64'h0);
        cfg_write(CFG_PAT_LEN, 64'd3);
        payload_q = '{8'h00};
        send_queued();
        payload_q = '{8'hFF};
        send_queued();
        // value with a lone cr inside
        payload_q = '{CH_CR, CH_LF, "H", "o", "s", "t", ":", " ",
                      "a", CH_CR, "b", CH_CR, CH_LF};
        send_queued();
        // empty value
        payload_q = '{CH_CR, CH_LF, "H", "o", "s", "t", ":", " ", CH_CR, CH_LF};
        send_queued();
        drain();

        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            case (ph / 2)
                0: begin
                    send_idle = 36;
                    recv_idle = 65;
                end
                1: begin
                    send_idle = 65;
                    recv_idle = 36;
                end
                default: begin
                    send_idle = 0;
                    recv_idle = 0;
                end
            endcase
            configure(ph);
            phase_start = sent_items;
            if (ph == 2 || ph == 5)
                send_payload(1'b1);
            while (sent_items - phase_start < PHASE_ITEMS)
                send_payload(1'b0);
            drain();
        end

        if (fail_count == 0 && pending == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial begin
        int stall;
        stall = 0;
        while (stall < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) || i_cfg_wen)
                stall = 0;
            else
                stall++;
        end
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// ----- sim.f -----
design/hhhm_pkg.sv
design/hhhm_scan.sv
design/hhhm_prefix.sv
design/http_host_header_matcher_unit.sv
verif/http_host_header_matcher_checker.sv
verif/http_host_header_matcher_unit_tb.sv
